>>> rtl/core/sjgs_pkg.sv
// Shared types, code constants and decode helpers for the Shift-JIS glyph sequencer.
package sjgs_pkg;

   // Font table geometry and half-width range
   localparam int unsigned FULL_LEAD_COUNT  = 47;
   localparam int unsigned FULL_TRAIL_COUNT = 188;
   localparam int unsigned HALF_FIRST       = 32;
   localparam int unsigned HALF_LAST        = 223;
   localparam int unsigned FULL_TABLE_SIZE  = FULL_LEAD_COUNT * FULL_TRAIL_COUNT;

   // Shift-JIS byte classes
   localparam logic [7:0] LEAD_LOW_FIRST   = 8'h81;
   localparam logic [7:0] LEAD_LOW_LAST    = 8'h9f;
   localparam logic [7:0] LEAD_HIGH_FIRST  = 8'he0;
   localparam logic [7:0] LEAD_HIGH_LAST   = 8'hef;
   localparam logic [7:0] LEAD_HIGH_BASE   = 8'hc1;
   localparam logic [7:0] TRAIL_LOW_FIRST  = 8'h40;
   localparam logic [7:0] TRAIL_LOW_LAST   = 8'h7e;
   localparam logic [7:0] TRAIL_HIGH_FIRST = 8'h80;
   localparam logic [7:0] TRAIL_HIGH_LAST  = 8'hfc;
   localparam logic [7:0] TRAIL_HIGH_BASE  = 8'h41;

   localparam logic [15:0] PEN_X_MAX = 16'h7fff;

   // Register map (word index)
   localparam logic [1:0] REG_START_X     = 2'd0;
   localparam logic [1:0] REG_TEXT_Y      = 2'd1;
   localparam logic [1:0] REG_GLYPH_SCALE = 2'd2;

   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [15:0] START_X_RESET     = 16'd0;
   localparam logic [15:0] TEXT_Y_RESET      = 16'd0;
   localparam logic [3:0]  GLYPH_SCALE_RESET = 4'd1;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [13:0] glyph_index;
      logic        full_width;
      logic        draw_enable;
      logic [15:0] pen_x;
      logic [15:0] pen_y;
      logic [15:0] next_x;
      logic        string_end;
   } sjgs_result_type;

   function automatic logic is_lead(input logic [7:0] b);
      return ((b >= LEAD_LOW_FIRST) && (b <= LEAD_LOW_LAST)) ||
             ((b >= LEAD_HIGH_FIRST) && (b <= LEAD_HIGH_LAST));
   endfunction

   function automatic logic trail_class(input logic [7:0] b);
      return ((b >= TRAIL_LOW_FIRST) && (b <= TRAIL_LOW_LAST)) ||
             ((b >= TRAIL_HIGH_FIRST) && (b <= TRAIL_HIGH_LAST));
   endfunction

   // Pen advance by 8 or 4 times the scale, saturating at the top of the range
   function automatic logic [15:0] next_pen(input logic [15:0] pen, input logic full,
                                            input logic [3:0] scale);
      logic [6:0]  adv;
      logic [16:0] sum;
      adv = full ? {scale, 3'b000} : {1'b0, scale, 2'b00};
      sum = {pen[15], pen} + {10'd0, adv};
      return (sum[16:15] == 2'b01) ? PEN_X_MAX : sum[15:0];
   endfunction

   function automatic logic [13:0] half_index(input logic [7:0] b);
      logic [8:0] d;
      d = {1'b0, b} - 9'(HALF_FIRST);
      return ((9'(b) >= 9'(HALF_FIRST)) && (9'(b) <= 9'(HALF_LAST))) ? {5'd0, d[8:0]} : 14'd0;
   endfunction

   // Row of a lead/trail pair; 16 bits so the table bound check sees the full value
   function automatic logic [15:0] full_row(input logic [7:0] lead, input logic [7:0] trail);
      logic [7:0]  l;
      logic [7:0]  t;
      l = (lead <= LEAD_LOW_LAST) ? lead - LEAD_LOW_FIRST : lead - LEAD_HIGH_BASE;
      t = (trail <= TRAIL_LOW_LAST) ? trail - TRAIL_LOW_FIRST : trail - TRAIL_HIGH_BASE;
      return (16'(l[5:0]) * 16'(FULL_TRAIL_COUNT)) + 16'(t);
   endfunction

endpackage

>>> rtl/core/shift_jis_glyph_sequencer_unit.sv
// Top level of the Shift-JIS glyph sequencer: register port, byte register, decode, result queue.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_text_byte, req_last_byte
//   rsp      out        rsp_valid / rsp_stall  rsp_glyph_index ... rsp_string_end
//   csr      in         APB write/read         csr_paddr, csr_pwdata, csr_prdata
//
// One byte per cycle while the queue has room: a byte waits in the input register,
// is decoded, and its zero, one or two results go into a four-entry queue as it leaves.
// Two results from one byte fill two queue entries, so the rate is set by the queue drain:
// one result per cycle while rsp_stall is low. The input stalls while the queue holds
// more than two results. Reset is synchronous and leaves no lead byte held, pen at start_x.
module shift_jis_glyph_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [13:0]                       rsp_glyph_index,
   output logic                              rsp_full_width,
   output logic                              rsp_draw_enable,
   output logic signed [15:0]                rsp_pen_x,
   output logic signed [15:0]                rsp_pen_y,
   output logic signed [15:0]                rsp_next_x,
   output logic                              rsp_string_end,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sjgs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import sjgs_pkg::*;

   logic [15:0] start_x_ff, text_y_ff;
   logic [3:0]  glyph_scale_ff;
   logic        csr_write;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        req_take, fire, room_for_two;

   logic [1:0]      push_count, dec_count;
   sjgs_result_type res_a, res_b, out_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_START_X:     csr_prdata = {16'd0, start_x_ff};
         REG_TEXT_Y:      csr_prdata = {16'd0, text_y_ff};
         REG_GLYPH_SCALE: csr_prdata = {28'd0, glyph_scale_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= START_X_RESET;
         text_y_ff      <= TEXT_Y_RESET;
         glyph_scale_ff <= GLYPH_SCALE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_START_X:     start_x_ff     <= csr_pwdata[15:0];
            REG_TEXT_Y:      text_y_ff      <= csr_pwdata[15:0];
            REG_GLYPH_SCALE: glyph_scale_ff <= csr_pwdata[3:0];
            default:         ;
         endcase
      end
   end

   // input register advances into decode whenever the queue can take two results
   assign fire      = in_valid_ff && room_for_two;
   assign req_stall = in_valid_ff && !room_for_two;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_last_byte;
      end
   end

   sjgs_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .text_byte   (in_byte_ff),
      .last_byte   (in_last_ff),
      .start_x     (start_x_ff),
      .text_y      (text_y_ff),
      .glyph_scale (glyph_scale_ff),
      .push_count  (dec_count),
      .res_a       (res_a),
      .res_b       (res_b)
   );

   assign push_count = fire ? dec_count : 2'd0;

   sjgs_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_a       (res_a),
      .push_b       (res_b),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_data     (out_data)
   );

   assign rsp_glyph_index = out_data.glyph_index;
   assign rsp_full_width  = out_data.full_width;
   assign rsp_draw_enable = out_data.draw_enable;
   assign rsp_pen_x       = $signed(out_data.pen_x);
   assign rsp_pen_y       = $signed(out_data.pen_y);
   assign rsp_next_x      = $signed(out_data.next_x);
   assign rsp_string_end  = out_data.string_end;

endmodule

>>> rtl/core/sjgs_decode.sv
// Byte decode, held-lead and pen state; produces up to two glyph results per byte.
module sjgs_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [7:0]               text_byte,
   input  logic                     last_byte,
   input  logic [15:0]              start_x,
   input  logic [15:0]              text_y,
   input  logic [3:0]               glyph_scale,
   output logic [1:0]               push_count,
   output sjgs_pkg::sjgs_result_type res_a,
   output sjgs_pkg::sjgs_result_type res_b
);
   import sjgs_pkg::*;

   logic [7:0]  held_lead_ff, held_lead_in;
   logic        held_valid_ff, held_valid_in;
   logic [15:0] pen_ff, pen_in;
   logic        at_start_ff;

   logic [15:0] pen0, pen_new, nx_full, nx_held, nx_new, row;
   logic        hold_new;
   sjgs_result_type full_res, held_res, new_res;

   always_comb begin
      pen0    = at_start_ff ? start_x : pen_ff;
      row     = full_row(held_lead_ff, text_byte);
      nx_full = next_pen(pen0, 1'b1, glyph_scale);
      nx_held = next_pen(pen0, 1'b0, glyph_scale);
      // second result starts where the flushed lead byte left the pen
      pen_new = held_valid_ff ? nx_held : pen0;
      nx_new  = next_pen(pen_new, 1'b0, glyph_scale);

      full_res.glyph_index = row[13:0];
      full_res.full_width  = 1'b1;
      full_res.draw_enable = (row < 16'(FULL_TABLE_SIZE));
      full_res.pen_x       = pen0;
      full_res.pen_y       = text_y;
      full_res.next_x      = nx_full;
      full_res.string_end  = last_byte;

      held_res.glyph_index = half_index(held_lead_ff);
      held_res.full_width  = 1'b0;
      held_res.draw_enable = 1'b1;
      held_res.pen_x       = pen0;
      held_res.pen_y       = text_y;
      held_res.next_x      = nx_held;
      held_res.string_end  = 1'b0;

      new_res.glyph_index  = half_index(text_byte);
      new_res.full_width   = 1'b0;
      new_res.draw_enable  = 1'b1;
      new_res.pen_x        = pen_new;
      new_res.pen_y        = text_y;
      new_res.next_x       = nx_new;
      new_res.string_end   = last_byte;

      hold_new = is_lead(text_byte) && !last_byte;

      priority if (held_valid_ff && trail_class(text_byte)) begin
         push_count    = 2'd1;
         res_a         = full_res;
         res_b         = new_res;
         pen_in        = nx_full;
         held_valid_in = 1'b0;
         held_lead_in  = held_lead_ff;
      end else begin
         push_count    = {1'b0, held_valid_ff} + {1'b0, !hold_new};
         res_a         = held_valid_ff ? held_res : new_res;
         res_b         = new_res;
         pen_in        = hold_new ? pen_new : nx_new;
         held_valid_in = hold_new;
         held_lead_in  = hold_new ? text_byte : held_lead_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         pen_ff        <= 16'd0;
         at_start_ff   <= 1'b1;
      end else if (fire) begin
         held_lead_ff  <= held_lead_in;
         held_valid_ff <= held_valid_in;
         pen_ff        <= pen_in;
         at_start_ff   <= last_byte;
      end
   end

endmodule

>>> rtl/core/sjgs_rsp_queue.sv
// Result queue: takes up to two results a cycle, hands out one.
module sjgs_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               push_count,
   input  sjgs_pkg::sjgs_result_type push_a,
   input  sjgs_pkg::sjgs_result_type push_b,
   output logic                     room_for_two,
   output logic                     out_valid,
   input  logic                     out_stall,
   output sjgs_pkg::sjgs_result_type out_data
);
   import sjgs_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   sjgs_result_type mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign out_valid    = (count_ff != '0);
   assign out_data     = mem[rd_ptr_ff];
   assign room_for_two = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign pop          = out_valid && !out_stall;
   assign wr_next      = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push_a;
      end
      if (push_count == 2'd2) begin
         mem[wr_next] <= push_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
